FILE: hw/rtl/lha_pkg.sv
// shared types, codes and constants of the latched hazard alarm
package lha_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CMD_W-1:0]    t_cmd;

    typedef enum logic [STATE_W-1:0] {
        ST_STANDBY  = 3'd0,
        ST_ACTIVE   = 3'd1,
        ST_GAS      = 3'd2,
        ST_BLACKOUT = 3'd3,
        ST_TEMP     = 3'd4,
        ST_MULTI    = 3'd5
    } t_alarm_state;

    localparam t_cmd CMD_ACTIVATE   = 2'd1;
    localparam t_cmd CMD_TEMP_RESET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_SET_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_CLEAR_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_RAW_LIMIT  = 3'd4;

    localparam t_sample RST_DROP_THRESHOLD  = 10'd300;
    localparam t_sample RST_BRIGHT_LEVEL    = 10'd400;
    localparam t_sample RST_GAS_SET_LEVEL   = 10'd180;
    localparam t_sample RST_GAS_CLEAR_LEVEL = 10'd130;
    localparam t_sample RST_TEMP_RAW_LIMIT  = 10'd194;

    typedef struct packed {
        t_sample drop_threshold;
        t_sample bright_level;
        t_sample gas_set_level;
        t_sample gas_clear_level;
        t_sample temp_raw_limit;
    } t_lha_cfg;

    typedef struct packed {
        t_alarm_state mode;
        t_sample      last_light;
        logic         last_light_valid;
        logic         armed;
        logic         temp_latch;
        logic         blackout_latch;
        logic         gas_latch;
    } t_lha_state;

    typedef struct packed {
        t_sample light_sample;
        t_sample gas_sample;
        t_sample temp_sample;
        t_cmd    command;
    } t_lha_item;

    typedef struct packed {
        logic [STATE_W-1:0] alarm_state;
        logic               door_lock;
        logic               buzzer_on;
    } t_lha_result;

endpackage

FILE: hw/rtl/lha_in_if.sv
// sample channel interface: light, gas, temperature and command
interface lha_in_if
    import lha_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample light_sample;
    t_sample gas_sample;
    t_sample temp_sample;
    t_cmd    command;

    modport source (
        output valid, light_sample, gas_sample, temp_sample, command,
        input  ready
    );
    modport sink (
        input  valid, light_sample, gas_sample, temp_sample, command,
        output ready
    );
endinterface

FILE: hw/rtl/lha_out_if.sv
// result channel interface: alarm state, door lock and buzzer
interface lha_out_if
    import lha_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] alarm_state;
    logic               door_lock;
    logic               buzzer_on;

    modport source (
        output valid, alarm_state, door_lock, buzzer_on,
        input  ready
    );
    modport sink (
        input  valid, alarm_state, door_lock, buzzer_on,
        output ready
    );
endinterface

FILE: hw/rtl/latched_hazard_alarm_fsm_core.sv
// latched hazard alarm top level: config, state registers and result queue
//
// channel   dir  handshake       payload
// i_in      in   valid / ready   light_sample, gas_sample, temp_sample, command
// o_res     out  valid / ready   alarm_state, door_lock, buzzer_on
// i_cfg_*   in   write enable    register index, 10-bit data
//
// one transaction per cycle while i_in.ready is high; its result is registered into
// a two-entry result buffer (output register plus skid) that decouples the sides,
// so input stalls only when both entries hold results not yet taken
// synchronous active-low reset restores register defaults and standby state
module latched_hazard_alarm_fsm_core
    import lha_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lha_in_if.sink               i_in,
    lha_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_sample              i_cfg_data
);

    t_lha_cfg    r_cfg;
    t_lha_state  r_state;
    t_lha_state  n_state;
    t_lha_item   item;
    t_lha_result result;
    t_lha_result r_out;
    t_lha_result r_skid;
    logic        r_out_v;
    logic        r_skid_v;
    logic        acc;
    logic        pop;

    assign item.light_sample = i_in.light_sample;
    assign item.gas_sample   = i_in.gas_sample;
    assign item.temp_sample  = i_in.temp_sample;
    assign item.command      = i_in.command;

    assign i_in.ready = !r_skid_v;
    assign acc        = i_in.valid && !r_skid_v;
    assign pop        = r_out_v && o_res.ready;

    lha_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_threshold  <= RST_DROP_THRESHOLD;
            r_cfg.bright_level    <= RST_BRIGHT_LEVEL;
            r_cfg.gas_set_level   <= RST_GAS_SET_LEVEL;
            r_cfg.gas_clear_level <= RST_GAS_CLEAR_LEVEL;
            r_cfg.temp_raw_limit  <= RST_TEMP_RAW_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DROP_THRESHOLD:  r_cfg.drop_threshold  <= i_cfg_data;
                REG_BRIGHT_LEVEL:    r_cfg.bright_level    <= i_cfg_data;
                REG_GAS_SET_LEVEL:   r_cfg.gas_set_level   <= i_cfg_data;
                REG_GAS_CLEAR_LEVEL: r_cfg.gas_clear_level <= i_cfg_data;
                REG_TEMP_RAW_LIMIT:  r_cfg.temp_raw_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode             <= ST_STANDBY;
            r_state.last_light       <= '0;
            r_state.last_light_valid <= 1'b0;
            r_state.armed            <= 1'b0;
            r_state.temp_latch       <= 1'b0;
            r_state.blackout_latch   <= 1'b0;
            r_state.gas_latch        <= 1'b0;
        end else if (acc) begin
            r_state <= n_state;
        end
    end

    // result buffer: output register in front, skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v) begin
            r_out_v <= acc;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= acc;
            end
        end else begin
            r_skid_v <= r_skid_v || acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || (pop && !r_skid_v)) begin
            if (acc) begin
                r_out <= result;
            end
        end else if (pop) begin
            r_out <= r_skid;
        end
        if (r_out_v && !pop && acc) begin
            r_skid <= result;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.alarm_state = r_out.alarm_state;
    assign o_res.door_lock   = r_out.door_lock;
    assign o_res.buzzer_on   = r_out.buzzer_on;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held with empty output register");

    a_armed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |=> r_state.armed)
        else $error("armed flag dropped");

    a_temp_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.command == CMD_TEMP_RESET)) |=> !r_state.temp_latch)
        else $error("temperature latch not cleared by reset command");

    a_mode_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_state.mode))
        else $error("mode changed without a transaction");

    a_result_holds_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_res.ready) |=> (r_out_v && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

FILE: hw/rtl/lha_step.sv
// next-state and result logic for one sample transaction
module lha_step
    import lha_pkg::*;
(
    input  t_lha_cfg    i_cfg,
    input  t_lha_state  i_state,
    input  t_lha_item   i_item,
    output t_lha_state  o_state,
    output t_lha_result o_result
);

    logic [SAMPLE_W:0] drop_amount;
    logic              drop_hit;
    logic              blackout;
    logic              gas;
    logic              temp;
    t_alarm_state      mode;
    logic              update;

    always_comb begin
        drop_amount = {1'b0, i_state.last_light} - {1'b0, i_item.light_sample};
        drop_hit    = i_state.last_light_valid
                   && (i_state.last_light > i_item.light_sample)
                   && (drop_amount > {1'b0, i_cfg.drop_threshold});

        // clear beats set on both latches
        blackout = (drop_hit || i_state.blackout_latch)
                && !(i_item.light_sample > i_cfg.bright_level);
        gas      = ((i_item.gas_sample > i_cfg.gas_set_level) || i_state.gas_latch)
                && !(i_item.gas_sample < i_cfg.gas_clear_level);
        temp     = i_state.temp_latch || (i_item.temp_sample > i_cfg.temp_raw_limit);

        update = temp || i_state.armed;
        if (temp) begin
            mode = ST_TEMP;
        end else if (i_state.armed) begin
            if (gas && blackout) begin
                mode = ST_MULTI;
            end else if (gas) begin
                mode = ST_GAS;
            end else if (blackout) begin
                mode = ST_BLACKOUT;
            end else begin
                mode = ST_ACTIVE;
            end
        end else begin
            mode = i_state.mode;
        end

        o_result.alarm_state = mode;
        o_result.door_lock   = (mode == ST_TEMP);
        o_result.buzzer_on   = (mode == ST_MULTI);

        // command takes effect after the result is formed
        o_state.blackout_latch   = blackout;
        o_state.gas_latch        = gas;
        o_state.last_light       = update ? i_item.light_sample : i_state.last_light;
        o_state.last_light_valid = update || i_state.last_light_valid;
        o_state.armed            = i_state.armed;
        o_state.temp_latch       = temp;
        o_state.mode             = mode;
        case (i_item.command)
            CMD_ACTIVATE: begin
                o_state.armed = 1'b1;
            end
            CMD_TEMP_RESET: begin
                o_state.temp_latch = 1'b0;
                if (!i_state.armed) begin
                    o_state.mode = ST_STANDBY;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: tb/sv/lha_alarm_checker.sv
// alarm checker: predicts each result from the accepted samples and compares it
`timescale 1ns / 1ps

module lha_alarm_checker
    import lha_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lha_in_if                    i_in,
    lha_out_if                   i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_sample              i_cfg_data,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending
);

    t_lha_cfg    alarm_cfg;
    t_lha_state  alarm_st;
    t_lha_result expected_alarms[$];
    t_lha_result want;
    t_lha_item   taken;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one tick of the alarm: latch updates, state update, then the command
    function automatic t_lha_result alarm_tick(input t_lha_item it);
        t_lha_result r;
        if (alarm_st.last_light_valid && alarm_st.last_light > it.light_sample &&
            (alarm_st.last_light - it.light_sample) > alarm_cfg.drop_threshold) begin
            alarm_st.blackout_latch = 1'b1;
        end
        if (it.light_sample > alarm_cfg.bright_level) begin
            alarm_st.blackout_latch = 1'b0;
        end
        if (it.gas_sample > alarm_cfg.gas_set_level) begin
            alarm_st.gas_latch = 1'b1;
        end
        if (it.gas_sample < alarm_cfg.gas_clear_level) begin
            alarm_st.gas_latch = 1'b0;
        end
        if (it.temp_sample > alarm_cfg.temp_raw_limit) begin
            alarm_st.temp_latch = 1'b1;
        end

        if (alarm_st.temp_latch) begin
            alarm_st.mode             = ST_TEMP;
            alarm_st.last_light       = it.light_sample;
            alarm_st.last_light_valid = 1'b1;
        end else if (alarm_st.armed) begin
            if (alarm_st.gas_latch && alarm_st.blackout_latch) begin
                alarm_st.mode = ST_MULTI;
            end else if (alarm_st.gas_latch) begin
                alarm_st.mode = ST_GAS;
            end else if (alarm_st.blackout_latch) begin
                alarm_st.mode = ST_BLACKOUT;
            end else begin
                alarm_st.mode = ST_ACTIVE;
            end
            alarm_st.last_light       = it.light_sample;
            alarm_st.last_light_valid = 1'b1;
        end

        r.alarm_state = alarm_st.mode;
        r.door_lock   = (alarm_st.mode == ST_TEMP);
        r.buzzer_on   = (alarm_st.mode == ST_MULTI);

        // command takes effect after the result is formed
        if (it.command == CMD_ACTIVATE) begin
            alarm_st.armed = 1'b1;
        end else if (it.command == CMD_TEMP_RESET) begin
            alarm_st.temp_latch = 1'b0;
            if (!alarm_st.armed) begin
                alarm_st.mode = ST_STANDBY;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alarm_cfg = '{RST_DROP_THRESHOLD, RST_BRIGHT_LEVEL, RST_GAS_SET_LEVEL,
                          RST_GAS_CLEAR_LEVEL, RST_TEMP_RAW_LIMIT};
            alarm_st      = '0;
            alarm_st.mode = ST_STANDBY;
            expected_alarms.delete();
        end else begin
            // compare before pushing so a result can never match its own transaction
            if (i_res.valid && i_res.ready) begin
                if (expected_alarms.size() == 0) begin
                    $display("%0t: unexpected result: state %0d lock %0b buzzer %0b",
                             $time, i_res.alarm_state, i_res.door_lock, i_res.buzzer_on);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_alarms.pop_front();
                    if (i_res.alarm_state !== want.alarm_state ||
                        i_res.door_lock !== want.door_lock ||
                        i_res.buzzer_on !== want.buzzer_on) begin
                        $display("%0t: result mismatch: expected state %0d lock %0b buzzer %0b,%s",
                                 $time, want.alarm_state, want.door_lock, want.buzzer_on,
                                 " actual below");
                        $display("%0t:   actual state %0d lock %0b buzzer %0b", $time,
                                 i_res.alarm_state, i_res.door_lock, i_res.buzzer_on);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                taken.light_sample = i_in.light_sample;
                taken.gas_sample   = i_in.gas_sample;
                taken.temp_sample  = i_in.temp_sample;
                taken.command      = i_in.command;
                expected_alarms.push_back(alarm_tick(taken));
            end

            // a register write applies from the next transaction on
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DROP_THRESHOLD:  alarm_cfg.drop_threshold  = i_cfg_data;
                    REG_BRIGHT_LEVEL:    alarm_cfg.bright_level    = i_cfg_data;
                    REG_GAS_SET_LEVEL:   alarm_cfg.gas_set_level   = i_cfg_data;
                    REG_GAS_CLEAR_LEVEL: alarm_cfg.gas_clear_level = i_cfg_data;
                    REG_TEMP_RAW_LIMIT:  alarm_cfg.temp_raw_limit  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_alarms.size();
    end

endmodule

FILE: tb/sv/tb.sv
// testbench top: clock, reset, sample stimulus, configuration phases and verdict
`timescale 1ns / 1ps

module tb;
    import lha_pkg::*;

    localparam t_cmd        CMD_NONE      = 2'd0;
    localparam t_cmd        CMD_SPARE     = 2'd2;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned SETTLE_CYCLES = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    t_sample              cfg_data;

    int unsigned alarm_failures;
    int unsigned alarms_pending;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;
    bit          hold_req;
    t_lha_cfg    cur_cfg;

    lha_in_if  in_ch ();
    lha_out_if res_ch ();

    latched_hazard_alarm_fsm_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lha_alarm_checker u_alarm_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (alarm_failures),
        .o_pending    (alarms_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, or one long hold-off when requested
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_sample(input t_sample light, input t_sample gas,
                               input t_sample temp, input t_cmd cmd);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.light_sample = light;
        in_ch.gas_sample   = gas;
        in_ch.temp_sample  = temp;
        in_ch.command      = cmd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random_sample();
        t_sample     temp;
        t_cmd        cmd;
        int unsigned roll;
        // keep temperature mostly below the limit so the latch does not swamp the rest
        if ($urandom_range(0, 99) < 20) begin
            temp = t_sample'($urandom_range(0, 1023));
        end else begin
            temp = t_sample'($urandom_range(0, cur_cfg.temp_raw_limit));
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            cmd = CMD_NONE;
        end else if (roll < 65) begin
            cmd = CMD_SPARE;
        end else if (roll < 75) begin
            cmd = CMD_ACTIVATE;
        end else begin
            cmd = CMD_TEMP_RESET;
        end
        send_sample(t_sample'($urandom_range(0, 1023)), t_sample'($urandom_range(0, 1023)),
                    temp, cmd);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        @(posedge i_clk);
        while (alarms_pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_sample val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_config(input t_sample drop, input t_sample bright,
                               input t_sample gas_set, input t_sample gas_clr,
                               input t_sample temp_lim);
        write_reg(REG_DROP_THRESHOLD, drop);
        write_reg(REG_BRIGHT_LEVEL, bright);
        write_reg(REG_GAS_SET_LEVEL, gas_set);
        write_reg(REG_GAS_CLEAR_LEVEL, gas_clr);
        write_reg(REG_TEMP_RAW_LIMIT, temp_lim);
        cur_cfg = '{drop, bright, gas_set, gas_clr, temp_lim};
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.light_sample = '0;
        in_ch.gas_sample   = '0;
        in_ch.temp_sample  = '0;
        in_ch.command      = CMD_NONE;
        cfg_we             = 1'b0;
        cfg_idx            = REG_DROP_THRESHOLD;
        cfg_data           = '0;
        idle_pct           = 0;
        stall_pct          = 0;
        hold_req           = 1'b0;
        quiet_cycles       = 0;
        cur_cfg            = '{RST_DROP_THRESHOLD, RST_BRIGHT_LEVEL, RST_GAS_SET_LEVEL,
                               RST_GAS_CLEAR_LEVEL, RST_TEMP_RAW_LIMIT};
        i_rst_n            = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unarmed: state only moves on temperature and on the temperature reset command
        send_sample(10'd0, 10'd0, 10'd0, CMD_NONE);
        send_sample(10'd1023, 10'd1023, 10'd194, CMD_SPARE);
        send_sample(10'd0, 10'd0, 10'd195, CMD_NONE);
        send_sample(10'd0, 10'd0, 10'd0, CMD_TEMP_RESET);
        send_sample(10'd0, 10'd0, 10'd0, CMD_NONE);
        send_sample(10'd1023, 10'd0, 10'd0, CMD_ACTIVATE);
        // armed: blackout, gas hysteresis, multi fault
        send_sample(10'd1023, 10'd0, 10'd0, CMD_NONE);
        send_sample(10'd0, 10'd0, 10'd0, CMD_NONE);
        send_sample(10'd0, 10'd1023, 10'd0, CMD_NONE);
        send_sample(10'd0, 10'd150, 10'd0, CMD_NONE);
        send_sample(10'd0, 10'd129, 10'd0, CMD_NONE);
        send_sample(10'd401, 10'd130, 10'd0, CMD_NONE);
        send_sample(10'd101, 10'd181, 10'd0, CMD_NONE);
        send_sample(10'd1023, 10'd180, 10'd0, CMD_NONE);
        // drop and bright in one transaction: bright wins
        send_sample(10'd401, 10'd0, 10'd0, CMD_NONE);
        // temperature while armed, cleared, recomputed on the next transaction
        send_sample(10'd100, 10'd0, 10'd1023, CMD_NONE);
        send_sample(10'd100, 10'd0, 10'd0, CMD_TEMP_RESET);
        send_sample(10'd100, 10'd0, 10'd0, CMD_NONE);
        send_sample(10'd512, 10'd682, 10'd0, CMD_ACTIVATE);
        send_sample(10'd341, 10'd341, 10'd341, CMD_SPARE);
        send_sample(10'd682, 10'd0, 10'd0, CMD_TEMP_RESET);
        drain_results();

        // set level below clear level: clear wins
        load_config(10'd0, 10'd1023, 10'd100, 10'd200, 10'd1023);
        send_sample(10'd1023, 10'd150, 10'd1023, CMD_NONE);
        send_sample(10'd1022, 10'd1023, 10'd0, CMD_NONE);
        send_sample(10'd1022, 10'd0, 10'd0, CMD_NONE);
        drain_results();

        for (int unsigned p = 0; p < PHASES; p++) begin
            case (p)
                0, 7: load_config(RST_DROP_THRESHOLD, RST_BRIGHT_LEVEL, RST_GAS_SET_LEVEL,
                                  RST_GAS_CLEAR_LEVEL, RST_TEMP_RAW_LIMIT);
                1: load_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
                2: load_config(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
                4: load_config(t_sample'($urandom_range(0, 1023)),
                               t_sample'($urandom_range(0, 1023)),
                               t_sample'($urandom_range(0, 511)),
                               t_sample'($urandom_range(512, 1023)),
                               t_sample'($urandom_range(0, 1023)));
                default: load_config(t_sample'($urandom_range(0, 1023)),
                                     t_sample'($urandom_range(0, 1023)),
                                     t_sample'($urandom_range(0, 1023)),
                                     t_sample'($urandom_range(0, 1023)),
                                     t_sample'($urandom_range(0, 1023)));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 0) begin
                hold_req = 1'b1;
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                send_random_sample();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (alarm_failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lha_pkg.sv
hw/rtl/lha_in_if.sv
hw/rtl/lha_out_if.sv
hw/rtl/lha_step.sv
hw/rtl/latched_hazard_alarm_fsm_core.sv
tb/sv/lha_alarm_checker.sv
tb/sv/tb.sv
